// ----- rtl/assert_macros.svh -----
// Assertion helpers for the sorted id table.
// Each macro takes a label, clock, active-low reset, property and message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define SIDS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

`define SIDS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);

`else

`define SIDS_ASSERT(lbl, clk, rst_n, prop, msg)

`define SIDS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// ----- rtl/sids_pkg.sv -----
`default_nettype none

package sids_pkg;

  localparam int CAPACITY      = 16;
  localparam int PAYLOAD_BITS  = 32;
  localparam int KEY_W         = 31;
  localparam int PAY_PORT_W    = 32;
  localparam int ENTRY_COUNT_W = 5;
  localparam int COUNT_W       = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_LOOKUP = 2'd2,
    REQ_COUNT  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    STS_OK     = 2'd0,
    STS_ABSENT = 2'd1,
    STS_DUP    = 2'd2,
    STS_FULL   = 2'd3
  } status_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;   // capture the request transaction
    logic exec;   // compare, shift and update in this cycle
  } cmd_t;

endpackage

`default_nettype wire

// ----- rtl/sids_ctrl.sv -----
`default_nettype none

module sids_ctrl
  import sids_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  output cmd_t      cmd_o,
  output logic      busy_o,
  output logic      done_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_q, state_d;
  logic done_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == S_EXEC);
    end
  end

  assign cmd_o.load = (state_q == S_IDLE) && start_i;
  assign cmd_o.exec = (state_q == S_EXEC);
  assign busy_o     = (state_q == S_EXEC);
  assign done_o     = done_q;

endmodule

`default_nettype wire

// ----- rtl/sids_datapath.sv -----
`default_nettype none

module sids_datapath
  import sids_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire cmd_t                     cmd_i,
  input  wire logic [1:0]               req_type_i,
  input  wire logic [KEY_W-1:0]         key_id_i,
  input  wire logic [PAY_PORT_W-1:0]    payload_in_i,
  output logic      [1:0]               status_o,
  output logic      [PAY_PORT_W-1:0]    payload_out_o,
  output logic      [ENTRY_COUNT_W-1:0] entry_count_o
);

  // Latched request
  req_e                    req_q;
  logic [KEY_W-1:0]        key_q;
  logic [PAYLOAD_BITS-1:0] pay_q;

  // Record cells, ascending in entries below count_q
  logic [KEY_W-1:0]        cell_key_q [CAPACITY];
  logic [PAYLOAD_BITS-1:0] cell_pay_q [CAPACITY];
  logic [COUNT_W-1:0]      count_q;

  logic [CAPACITY-1:0]     lt, eq;
  logic                    hit, full, ins_ok, rem_ok;
  logic [PAYLOAD_BITS-1:0] found_pay;

  status_e                 status_q, status_d;
  logic [PAY_PORT_W-1:0]   pout_q, pout_d;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_e'(req_type_i);
      key_q <= key_id_i;
      pay_q <= PAYLOAD_BITS'(payload_in_i);
    end
  end

  // Parallel compare; lt is a prefix since the cells are sorted
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cmp
    logic vld;
    assign vld   = COUNT_W'(i) < count_q;
    assign lt[i] = vld && (cell_key_q[i] < key_q);
    assign eq[i] = vld && (cell_key_q[i] == key_q);
  end

  always_comb begin
    found_pay = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (eq[i]) found_pay = found_pay | cell_pay_q[i];
    end
  end

  assign hit    = |eq;
  assign full   = (count_q == COUNT_W'(CAPACITY));
  assign ins_ok = cmd_i.exec && (req_q == REQ_INSERT) && !hit && !full;
  assign rem_ok = cmd_i.exec && (req_q == REQ_REMOVE) && hit;

  // Shift step: insert opens a gap at the first non-lower cell,
  // remove closes the gap left by the matching cell.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic first_ge;
    if (i == 0) begin : g_head
      assign first_ge = !lt[i];
    end else begin : g_body
      assign first_ge = !lt[i] && lt[i-1];
    end

    always_ff @(posedge clk_i) begin
      if (ins_ok && !lt[i]) begin
        if (first_ge) begin
          cell_key_q[i] <= key_q;
          cell_pay_q[i] <= pay_q;
        end else begin
          cell_key_q[i] <= cell_key_q[(i == 0) ? 0 : i-1];
          cell_pay_q[i] <= cell_pay_q[(i == 0) ? 0 : i-1];
        end
      end else if (rem_ok && !lt[i] && (i < CAPACITY - 1)) begin
        cell_key_q[i] <= cell_key_q[(i < CAPACITY - 1) ? i+1 : i];
        cell_pay_q[i] <= cell_pay_q[(i < CAPACITY - 1) ? i+1 : i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (ins_ok) begin
      count_q <= count_q + COUNT_W'(1);
    end else if (rem_ok) begin
      count_q <= count_q - COUNT_W'(1);
    end
  end

  always_comb begin
    pout_d   = '0;
    status_d = STS_OK;
    case (req_q)
      REQ_INSERT: begin
        if (hit)       status_d = STS_DUP;
        else if (full) status_d = STS_FULL;
      end
      REQ_REMOVE: begin
        if (!hit) status_d = STS_ABSENT;
      end
      REQ_LOOKUP: begin
        if (hit) pout_d   = PAY_PORT_W'(found_pay);
        else     status_d = STS_ABSENT;
      end
      default: begin
        status_d = STS_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      pout_q   <= pout_d;
      status_q <= status_d;
    end
  end

  assign status_o      = status_q;
  assign payload_out_o = pout_q;
  assign entry_count_o = ENTRY_COUNT_W'(count_q);

endmodule

`default_nettype wire

// ----- rtl/sorted_id_set_table.sv -----
// Sorted id table: bounded set of (id, payload) records kept in ascending id order.
// A transaction accepted while idle is captured by load, then compared and shifted in
// the single busy cycle; the result registers and done_o are updated at the end of it.
// A new transaction is not taken while busy is high; the parallel compare over all
// cells and the shift both run in that busy cycle. The receiver cannot stall done_o.
// In the datapath, reset clears the record count only; cell contents are undefined until written.
`default_nettype none
`include "assert_macros.svh"

module sorted_id_set_table
  import sids_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [1:0]               req_type_i,
  input  wire logic [KEY_W-1:0]         key_id_i,
  input  wire logic [PAY_PORT_W-1:0]    payload_in_i,
  output logic                          done_o,
  output logic      [1:0]               status_o,
  output logic      [PAY_PORT_W-1:0]    payload_out_o,
  output logic      [ENTRY_COUNT_W-1:0] entry_count_o
);

  // Command bundle from the controller: load captures the request transaction
  // at the accepting edge, exec runs the compare-and-shift across the cells.
  cmd_t cmd;

  sids_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  // Datapath: request latch, sorted cell chain, record count and result
  // registers. The result registers hold steady while done_o is high.
  sids_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .req_type_i    (req_type_i),
    .key_id_i      (key_id_i),
    .payload_in_i  (payload_in_i),
    .status_o      (status_o),
    .payload_out_o (payload_out_o),
    .entry_count_o (entry_count_o)
  );

  // Accepting a transaction always leads to one busy cycle, then its result.
  `SIDS_ASSERT(a_accept_busy, clk_i, rst_ni, cmd.load |=> busy, "accept did not go busy")
  `SIDS_ASSERT(a_busy_done, clk_i, rst_ni, busy |=> (done_o && !busy), "busy without result")
  // The compare-and-shift never runs outside the busy cycle.
  `SIDS_ASSERT_NEVER(a_exec_idle, clk_i, rst_ni, cmd.exec && !busy, "exec while idle")
  // Record count never passes the capacity.
  `SIDS_ASSERT_NEVER(a_count_cap, clk_i, rst_ni,
    entry_count_o > ENTRY_COUNT_W'(CAPACITY), "record count above capacity")

endmodule

`default_nettype wire
